// ----- design/buddy_page_allocator_core_macros.svh -----
// assertion macros for the buddy page allocator
// expect signals clk and rst in the scope of the user
`ifndef BUDDY_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_CORE_MACROS_SVH

// plain property under reset
`define BPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same cycle implication
`define BPA_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next cycle implication
`define BPA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- design/bpa_pkg.sv -----
// shared types and constants of the buddy page allocator
// no dependencies
`default_nettype none

package bpa_pkg;

  localparam int MAX_PAGES_DEF = 1024;
  localparam int MAX_ORDER_DEF = 10;
  localparam int ADDR_W = 48;
  localparam int BYTES_W = 32;
  localparam int MARK_W = 6;
  localparam int PS_MIN = 4;
  localparam int PS_MAX = 16;
  localparam int PAGES_W = BYTES_W - PS_MIN + 1;
  localparam int IN_W = 88;
  localparam int OUT_W = 56;
  localparam int CFG_W = 48;

  localparam logic [MARK_W-1:0] MARK_CHILD = 6'd63;
  localparam logic [MARK_W-1:0] MARK_USED = 6'd32;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE = 2'd1;
  localparam logic [1:0] OP_INIT = 2'd2;

  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_NONE = 2'd1;
  localparam logic [1:0] STAT_SIZE = 2'd2;
  localparam logic [1:0] STAT_ADDR = 2'd3;

  localparam logic [1:0] REG_BASE = 2'd0;
  localparam logic [1:0] REG_PSIZE = 2'd1;
  localparam logic [1:0] REG_PCOUNT = 2'd2;
  localparam logic [1:0] REG_OLIMIT = 2'd3;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISP, S_INIT_CLR, S_INIT_LG, S_INIT_TOP, S_INIT_CARVE,
    S_INIT_LINK, S_AL_WANT, S_AL_FIND, S_SP_RD, S_SP_A, S_SP_B, S_AL_RD,
    S_AL_POP, S_FR_RD, S_FR_CHK, S_MG_TEST, S_MG_CHK, S_UL_HPOP, S_UL_CHK,
    S_UL_FIX, S_MG_M1, S_MG_M2, S_FR_END, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    U_NONE, U_CLEAR, U_TAKE, U_RES, U_LG, U_TOP, U_DEC, U_CARVE, U_TAIL,
    U_INIT_RES, U_WANT, U_FIND_INIT, U_FIND_NEXT, U_SP_RD, U_SP_A, U_SP_B,
    U_AL_RD, U_AL_POP, U_FR_IDX, U_MK_RD, U_FR_ORD, U_MG_RD, U_UL_START,
    U_UL_HPOP, U_UL_STEP, U_UL_NRD, U_UL_FIX, U_MG_M1, U_MG_M2, U_FR_END,
    U_EMIT
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic take;
    logic [1:0] code;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic bytes_zero;
    logic free_bad;
    logic cnt_last;
    logic lg_more;
    logic carve_end;
    logic carve_fit;
    logic want_big;
    logic want_ok;
    logic find_over;
    logic find_hit;
    logic c_is_want;
    logic c_next_want;
    logic mark_used;
    logic merge_stop;
    logic mk_match;
    logic hv_ord;
    logic head_buddy;
    logic link_valid;
    logic link_buddy;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- design/bpa_ram.sv -----
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/bpa_ctrl.sv -----
// sequencer of the buddy page allocator
// depends on bpa_pkg
`default_nettype none

module bpa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire bpa_pkg::stat_t st,
  output bpa_pkg::cmd_t       cmd
);

  bpa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpa_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.uop = bpa_pkg::U_NONE;
    cmd.take = 1'b0;
    cmd.code = bpa_pkg::STAT_OK;
    unique case (state)
      bpa_pkg::S_CLEAR: begin
        cmd.uop = bpa_pkg::U_CLEAR;
        if (st.cnt_last) state_next = bpa_pkg::S_IDLE;
      end
      bpa_pkg::S_IDLE: begin
        cmd.take = 1'b1;
        if (in_valid) begin
          cmd.uop = bpa_pkg::U_TAKE;
          state_next = bpa_pkg::S_DISP;
        end
      end
      bpa_pkg::S_DISP: begin
        if (st.op == bpa_pkg::OP_INIT) begin
          state_next = bpa_pkg::S_INIT_CLR;
        end else if (st.op == bpa_pkg::OP_ALLOC && !st.bytes_zero) begin
          state_next = bpa_pkg::S_AL_WANT;
        end else if (st.op == bpa_pkg::OP_FREE && !st.free_bad) begin
          cmd.uop = bpa_pkg::U_FR_IDX;
          state_next = bpa_pkg::S_FR_RD;
        end else begin
          cmd.uop = bpa_pkg::U_RES;
          cmd.code = (st.op == bpa_pkg::OP_FREE) ? bpa_pkg::STAT_ADDR : bpa_pkg::STAT_SIZE;
          state_next = bpa_pkg::S_DONE;
        end
      end
      bpa_pkg::S_INIT_CLR: begin
        cmd.uop = bpa_pkg::U_CLEAR;
        if (st.cnt_last) state_next = bpa_pkg::S_INIT_LG;
      end
      bpa_pkg::S_INIT_LG: begin
        if (st.lg_more) begin
          cmd.uop = bpa_pkg::U_LG;
        end else begin
          state_next = bpa_pkg::S_INIT_TOP;
        end
      end
      bpa_pkg::S_INIT_TOP: begin
        cmd.uop = bpa_pkg::U_TOP;
        state_next = bpa_pkg::S_INIT_CARVE;
      end
      bpa_pkg::S_INIT_CARVE: begin
        if (st.carve_end) begin
          cmd.uop = bpa_pkg::U_INIT_RES;
          state_next = bpa_pkg::S_DONE;
        end else if (!st.carve_fit) begin
          cmd.uop = bpa_pkg::U_DEC;
        end else begin
          cmd.uop = bpa_pkg::U_CARVE;
          state_next = bpa_pkg::S_INIT_LINK;
        end
      end
      bpa_pkg::S_INIT_LINK: begin
        cmd.uop = bpa_pkg::U_TAIL;
        state_next = bpa_pkg::S_INIT_CARVE;
      end
      bpa_pkg::S_AL_WANT: begin
        if (st.want_big) begin
          cmd.uop = bpa_pkg::U_RES;
          cmd.code = bpa_pkg::STAT_SIZE;
          state_next = bpa_pkg::S_DONE;
        end else if (st.want_ok) begin
          cmd.uop = bpa_pkg::U_FIND_INIT;
          state_next = bpa_pkg::S_AL_FIND;
        end else begin
          cmd.uop = bpa_pkg::U_WANT;
        end
      end
      bpa_pkg::S_AL_FIND: begin
        if (st.find_over) begin
          cmd.uop = bpa_pkg::U_RES;
          cmd.code = bpa_pkg::STAT_NONE;
          state_next = bpa_pkg::S_DONE;
        end else if (!st.find_hit) begin
          cmd.uop = bpa_pkg::U_FIND_NEXT;
        end else if (st.c_is_want) begin
          state_next = bpa_pkg::S_AL_RD;
        end else begin
          state_next = bpa_pkg::S_SP_RD;
        end
      end
      bpa_pkg::S_SP_RD: begin
        cmd.uop = bpa_pkg::U_SP_RD;
        state_next = bpa_pkg::S_SP_A;
      end
      bpa_pkg::S_SP_A: begin
        cmd.uop = bpa_pkg::U_SP_A;
        state_next = bpa_pkg::S_SP_B;
      end
      bpa_pkg::S_SP_B: begin
        cmd.uop = bpa_pkg::U_SP_B;
        state_next = st.c_next_want ? bpa_pkg::S_AL_RD : bpa_pkg::S_SP_RD;
      end
      bpa_pkg::S_AL_RD: begin
        cmd.uop = bpa_pkg::U_AL_RD;
        state_next = bpa_pkg::S_AL_POP;
      end
      bpa_pkg::S_AL_POP: begin
        cmd.uop = bpa_pkg::U_AL_POP;
        state_next = bpa_pkg::S_DONE;
      end
      bpa_pkg::S_FR_RD: begin
        cmd.uop = bpa_pkg::U_MK_RD;
        state_next = bpa_pkg::S_FR_CHK;
      end
      bpa_pkg::S_FR_CHK: begin
        if (st.mark_used) begin
          cmd.uop = bpa_pkg::U_FR_ORD;
          state_next = bpa_pkg::S_MG_TEST;
        end else begin
          cmd.uop = bpa_pkg::U_RES;
          cmd.code = bpa_pkg::STAT_ADDR;
          state_next = bpa_pkg::S_DONE;
        end
      end
      bpa_pkg::S_MG_TEST: begin
        if (st.merge_stop) begin
          state_next = bpa_pkg::S_FR_END;
        end else begin
          cmd.uop = bpa_pkg::U_MG_RD;
          state_next = bpa_pkg::S_MG_CHK;
        end
      end
      bpa_pkg::S_MG_CHK: begin
        if (!st.mk_match || !st.hv_ord) begin
          state_next = bpa_pkg::S_FR_END;
        end else begin
          cmd.uop = bpa_pkg::U_UL_START;
          state_next = st.head_buddy ? bpa_pkg::S_UL_HPOP : bpa_pkg::S_UL_CHK;
        end
      end
      bpa_pkg::S_UL_HPOP: begin
        cmd.uop = bpa_pkg::U_UL_HPOP;
        state_next = bpa_pkg::S_MG_M1;
      end
      bpa_pkg::S_UL_CHK: begin
        if (!st.link_valid) begin
          state_next = bpa_pkg::S_FR_END;
        end else if (st.link_buddy) begin
          cmd.uop = bpa_pkg::U_UL_NRD;
          state_next = bpa_pkg::S_UL_FIX;
        end else begin
          cmd.uop = bpa_pkg::U_UL_STEP;
        end
      end
      bpa_pkg::S_UL_FIX: begin
        cmd.uop = bpa_pkg::U_UL_FIX;
        state_next = bpa_pkg::S_MG_M1;
      end
      bpa_pkg::S_MG_M1: begin
        cmd.uop = bpa_pkg::U_MG_M1;
        state_next = bpa_pkg::S_MG_M2;
      end
      bpa_pkg::S_MG_M2: begin
        cmd.uop = bpa_pkg::U_MG_M2;
        state_next = bpa_pkg::S_MG_TEST;
      end
      bpa_pkg::S_FR_END: begin
        cmd.uop = bpa_pkg::U_FR_END;
        state_next = bpa_pkg::S_DONE;
      end
      bpa_pkg::S_DONE: begin
        if (st.out_free) begin
          cmd.uop = bpa_pkg::U_EMIT;
          state_next = bpa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bpa_pkg::S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/bpa_dpath.sv -----
// datapath of the buddy page allocator: config, list heads, page mark and link rams
// depends on bpa_pkg, bpa_ram and the assertion macro header
`default_nettype none
`include "buddy_page_allocator_core_macros.svh"

module bpa_dpath #(
  parameter int MAX_PAGES = bpa_pkg::MAX_PAGES_DEF,
  parameter int MAX_ORDER = bpa_pkg::MAX_ORDER_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire bpa_pkg::cmd_t              cmd,
  output bpa_pkg::stat_t                  st,
  input  wire logic [bpa_pkg::IN_W-1:0]   in_data,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [bpa_pkg::CFG_W-1:0]  cfg_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [bpa_pkg::OUT_W-1:0]       out_data
);

  localparam int PW = $clog2(MAX_PAGES);
  localparam int CW = $clog2(MAX_PAGES + 1);
  localparam int HW = $clog2(MAX_ORDER + 1);
  localparam int OW = $clog2(MAX_ORDER + 2);
  localparam int LW = $clog2(PW + 2);
  localparam int XW = (CW > 11) ? CW : 11;
  localparam int AW = bpa_pkg::ADDR_W;
  localparam int GW = bpa_pkg::PAGES_W;

  // config
  logic [AW-1:0] base;
  logic [4:0]    psl;
  logic [10:0]   pcount;
  logic [3:0]    olimit;

  // latched item
  logic [1:0]              op;
  logic [bpa_pkg::BYTES_W-1:0] bytes;
  logic [AW-1:0]           faddr;

  // working registers
  logic [CW-1:0] cnt;
  logic [LW-1:0] lg;
  logic [OW-1:0] cur, want, c, order, top;
  logic [PW-1:0] tail, tail_old, lo, hi, idx, buddy, ucur;
  logic          lnk_pend;
  logic [PW-1:0] head [MAX_ORDER+1];
  logic [MAX_ORDER:0] hvalid;

  logic [1:0]    res_status;
  logic [AW-1:0] res_addr;
  logic [OW-1:0] res_order;

  // rams
  logic                      mk_we;
  logic [PW-1:0]             mk_waddr, mk_raddr;
  logic [bpa_pkg::MARK_W-1:0] mk_wdata, mk_rdata;
  logic                      lk_we;
  logic [PW-1:0]             lk_waddr, lk_raddr;
  logic [PW:0]               lk_wdata, lk_rdata;

  bpa_ram #(.WIDTH(bpa_pkg::MARK_W), .DEPTH(MAX_PAGES)) u_marks (
    .clk(clk), .we(mk_we), .waddr(mk_waddr), .wdata(mk_wdata),
    .raddr(mk_raddr), .rdata(mk_rdata)
  );

  bpa_ram #(.WIDTH(PW + 1), .DEPTH(MAX_PAGES)) u_links (
    .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
    .raddr(lk_raddr), .rdata(lk_rdata)
  );

  // derived values
  logic [4:0]          ps;
  logic [CW-1:0]       pc;
  logic [XW-1:0]       pc_ext;
  logic [GW-1:0]       pages;
  logic [bpa_pkg::BYTES_W-1:0] brem;
  logic [AW-1:0]       off;
  logic [PW-1:0]       free_idx;
  logic [CW-1:0]       buddy_c;
  logic [CW-1:0]       hi_sum;
  logic [PW-1:0]       hi_c;
  logic [OW-1:0]       cm1;
  logic [4:0]          top_c;
  logic [CW:0]         lg_lim;
  logic [CW:0]         carve_sum;

  always_comb begin
    if (psl < 5'(bpa_pkg::PS_MIN)) ps = 5'(bpa_pkg::PS_MIN);
    else if (psl > 5'(bpa_pkg::PS_MAX)) ps = 5'(bpa_pkg::PS_MAX);
    else ps = psl;
    pc_ext = XW'(pcount);
    pc = (pc_ext > XW'(MAX_PAGES)) ? CW'(MAX_PAGES) : CW'(pc_ext);
    brem = bytes & ((bpa_pkg::BYTES_W'(1) << ps) - bpa_pkg::BYTES_W'(1));
    pages = GW'(bytes >> ps) + GW'(brem != '0);
    off = faddr - base;
    free_idx = PW'(off >> ps);
    buddy_c = CW'(idx) ^ (CW'(1) << order);
    cm1 = c - OW'(1);
    hi_sum = CW'(lo) + (CW'(1) << cm1);
    hi_c = (hi_sum >= CW'(MAX_PAGES)) ? PW'(MAX_PAGES - 1) : PW'(hi_sum);
    top_c = 5'(lg);
    if (top_c > 5'(olimit)) top_c = 5'(olimit);
    if (top_c > 5'(MAX_ORDER)) top_c = 5'(MAX_ORDER);
    lg_lim = (CW+1)'(2) << lg;
    carve_sum = (CW+1)'(cnt) + ((CW+1)'(1) << cur);
  end

  always_comb begin
    st.op = op;
    st.bytes_zero = (bytes == '0);
    st.free_bad = (faddr < base)
        || ((off & ((AW'(1) << ps) - AW'(1))) != '0)
        || (((off >> ps) >> PW) != '0);
    st.cnt_last = (cnt == CW'(MAX_PAGES - 1));
    st.lg_more = (lg_lim <= (CW+1)'(pc));
    st.carve_end = (cnt >= pc);
    st.carve_fit = (carve_sum <= (CW+1)'(pc));
    st.want_big = (want > top);
    st.want_ok = ((GW'(1) << want) >= pages);
    st.find_over = (c > top);
    st.find_hit = hvalid[c[HW-1:0]];
    st.c_is_want = (c == want);
    st.c_next_want = (cm1 == want);
    st.mark_used = (mk_rdata >= bpa_pkg::MARK_USED)
        && (mk_rdata <= bpa_pkg::MARK_USED + bpa_pkg::MARK_W'(MAX_ORDER));
    st.merge_stop = (order >= top) || (buddy_c >= CW'(MAX_PAGES));
    st.mk_match = (mk_rdata == bpa_pkg::MARK_W'(order));
    st.hv_ord = hvalid[order[HW-1:0]];
    st.head_buddy = (head[order[HW-1:0]] == buddy);
    st.link_valid = lk_rdata[PW];
    st.link_buddy = (lk_rdata[PW-1:0] == buddy);
    st.out_free = !out_valid || out_ready;
  end

  // ram ports
  always_comb begin
    mk_we = 1'b0;
    mk_waddr = idx;
    mk_wdata = bpa_pkg::MARK_CHILD;
    mk_raddr = idx;
    lk_we = 1'b0;
    lk_waddr = idx;
    lk_wdata = '0;
    lk_raddr = ucur;
    case (cmd.uop)
      bpa_pkg::U_CLEAR: begin
        mk_we = 1'b1;
        mk_waddr = cnt[PW-1:0];
      end
      bpa_pkg::U_CARVE: begin
        mk_we = 1'b1;
        mk_waddr = cnt[PW-1:0];
        mk_wdata = bpa_pkg::MARK_W'(cur);
        lk_we = 1'b1;
        lk_waddr = cnt[PW-1:0];
      end
      bpa_pkg::U_TAIL: begin
        lk_we = lnk_pend;
        lk_waddr = tail_old;
        lk_wdata = {1'b1, tail};
      end
      bpa_pkg::U_SP_RD: lk_raddr = head[c[HW-1:0]];
      bpa_pkg::U_SP_A: begin
        lk_we = 1'b1;
        lk_waddr = hi_c;
        lk_wdata = {hvalid[cm1[HW-1:0]], head[cm1[HW-1:0]]};
        mk_we = 1'b1;
        mk_waddr = lo;
        mk_wdata = bpa_pkg::MARK_W'(cm1);
      end
      bpa_pkg::U_SP_B: begin
        lk_we = 1'b1;
        lk_waddr = lo;
        lk_wdata = {1'b1, hi};
        mk_we = 1'b1;
        mk_waddr = hi;
        mk_wdata = bpa_pkg::MARK_W'(cm1);
      end
      bpa_pkg::U_AL_RD: lk_raddr = head[want[HW-1:0]];
      bpa_pkg::U_AL_POP: begin
        mk_we = 1'b1;
        mk_wdata = bpa_pkg::MARK_USED + bpa_pkg::MARK_W'(want);
      end
      bpa_pkg::U_MG_RD: mk_raddr = PW'(buddy_c);
      bpa_pkg::U_UL_START: lk_raddr = head[order[HW-1:0]];
      bpa_pkg::U_UL_STEP, bpa_pkg::U_UL_NRD: lk_raddr = lk_rdata[PW-1:0];
      bpa_pkg::U_UL_FIX: begin
        lk_we = 1'b1;
        lk_waddr = ucur;
        lk_wdata = lk_rdata;
      end
      bpa_pkg::U_MG_M1: begin
        mk_we = 1'b1;
        mk_waddr = buddy;
      end
      bpa_pkg::U_MG_M2: mk_we = 1'b1;
      bpa_pkg::U_FR_END: begin
        mk_we = 1'b1;
        mk_wdata = bpa_pkg::MARK_W'(order);
        lk_we = 1'b1;
        lk_wdata = {hvalid[order[HW-1:0]], head[order[HW-1:0]]};
      end
      default: begin
      end
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
      psl <= 5'd12;
      pcount <= 11'd1024;
      olimit <= 4'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpa_pkg::REG_BASE:   base <= cfg_data[AW-1:0];
        bpa_pkg::REG_PSIZE:  psl <= cfg_data[4:0];
        bpa_pkg::REG_PCOUNT: pcount <= cfg_data[10:0];
        bpa_pkg::REG_OLIMIT: olimit <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      hvalid <= '0;
      top <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.uop == bpa_pkg::U_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.uop)
        bpa_pkg::U_CLEAR: begin
          cnt <= st.cnt_last ? '0 : cnt + CW'(1);
          hvalid <= '0;
          top <= '0;
        end
        bpa_pkg::U_TOP: top <= OW'(top_c);
        bpa_pkg::U_CARVE: begin
          if (!hvalid[cur[HW-1:0]]) hvalid[cur[HW-1:0]] <= 1'b1;
          cnt <= CW'(carve_sum);
        end
        bpa_pkg::U_INIT_RES: cnt <= '0;
        bpa_pkg::U_SP_A: hvalid[c[HW-1:0]] <= lk_rdata[PW];
        bpa_pkg::U_SP_B: hvalid[cm1[HW-1:0]] <= 1'b1;
        bpa_pkg::U_AL_POP: hvalid[want[HW-1:0]] <= lk_rdata[PW];
        bpa_pkg::U_UL_HPOP: hvalid[order[HW-1:0]] <= lk_rdata[PW];
        bpa_pkg::U_FR_END: hvalid[order[HW-1:0]] <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.uop)
      bpa_pkg::U_TAKE: begin
        op <= in_data[1:0];
        bytes <= in_data[33:2];
        faddr <= in_data[81:34];
        want <= '0;
        lg <= '0;
      end
      bpa_pkg::U_RES: begin
        res_status <= cmd.code;
        res_addr <= '0;
        res_order <= '0;
      end
      bpa_pkg::U_LG: lg <= lg + LW'(1);
      bpa_pkg::U_TOP: cur <= OW'(top_c);
      bpa_pkg::U_DEC: cur <= cur - OW'(1);
      bpa_pkg::U_CARVE: begin
        if (!hvalid[cur[HW-1:0]]) head[cur[HW-1:0]] <= cnt[PW-1:0];
        lnk_pend <= hvalid[cur[HW-1:0]];
        tail_old <= tail;
        tail <= cnt[PW-1:0];
      end
      bpa_pkg::U_INIT_RES: begin
        res_status <= bpa_pkg::STAT_OK;
        res_addr <= '0;
        res_order <= top;
      end
      bpa_pkg::U_WANT: want <= want + OW'(1);
      bpa_pkg::U_FIND_INIT: c <= want;
      bpa_pkg::U_FIND_NEXT: c <= c + OW'(1);
      bpa_pkg::U_SP_RD: lo <= head[c[HW-1:0]];
      bpa_pkg::U_SP_A: begin
        head[c[HW-1:0]] <= lk_rdata[PW-1:0];
        hi <= hi_c;
      end
      bpa_pkg::U_SP_B: begin
        head[cm1[HW-1:0]] <= lo;
        c <= cm1;
      end
      bpa_pkg::U_AL_RD: idx <= head[want[HW-1:0]];
      bpa_pkg::U_AL_POP: begin
        head[want[HW-1:0]] <= lk_rdata[PW-1:0];
        res_status <= bpa_pkg::STAT_OK;
        res_addr <= base + (AW'(idx) << ps);
        res_order <= want;
      end
      bpa_pkg::U_FR_IDX: idx <= free_idx;
      bpa_pkg::U_FR_ORD: order <= OW'(mk_rdata - bpa_pkg::MARK_USED);
      bpa_pkg::U_MG_RD: buddy <= PW'(buddy_c);
      bpa_pkg::U_UL_START: ucur <= head[order[HW-1:0]];
      bpa_pkg::U_UL_HPOP: head[order[HW-1:0]] <= lk_rdata[PW-1:0];
      bpa_pkg::U_UL_STEP: ucur <= lk_rdata[PW-1:0];
      bpa_pkg::U_MG_M2: begin
        if (buddy < idx) idx <= buddy;
        order <= order + OW'(1);
      end
      bpa_pkg::U_FR_END: begin
        head[order[HW-1:0]] <= idx;
        res_status <= bpa_pkg::STAT_OK;
        res_addr <= '0;
        res_order <= order;
      end
      bpa_pkg::U_EMIT: out_data <= {2'b00, 4'(res_order), res_addr, res_status};
      default: begin
      end
    endcase
  end

  `BPA_ASSERT(a_top_in_range, top <= OW'(MAX_ORDER), "top order beyond the largest order")
  `BPA_ASSERT_IMP(a_split_above_want, cmd.uop == bpa_pkg::U_SP_B, c > want, "split too low")
  `BPA_ASSERT_NEXT(a_emit_sets_valid, cmd.uop == bpa_pkg::U_EMIT, out_valid, "word not shown")
  `BPA_ASSERT_IMP(a_emit_slot_free, cmd.uop == bpa_pkg::U_EMIT, !out_valid || out_ready, "word lost")

endmodule

`default_nettype wire

// ----- design/buddy_page_allocator_core.sv -----
// top level of the buddy page allocator: sequencer plus datapath
// depends on bpa_pkg, bpa_ctrl, bpa_dpath and bpa_ram
//
// channel   dir  handshake          contents
// s_*       in   tvalid / tready    operation, request_bytes, free_address
// m_*       out  tvalid / tready    status, block_address, block_order
// cfg_*     in   cfg_we             register index and write data
//
// after reset a clearing pass over all MAX_PAGES page marks runs before s_tready rises
// initialize: a page mark clearing pass, the top order from page count and order limit,
// then blocks carved from page 0 upward, stepping the order down where it does not fit
// allocate: find the wanted order, search upward for a non-empty list, split down, pop
// free: check the mark, merge with each free buddy, unlinking it from its list, then push
// one result register on the output; the next word is taken while it waits
`default_nettype none

module buddy_page_allocator_core #(
  parameter int MAX_PAGES = bpa_pkg::MAX_PAGES_DEF,
  parameter int MAX_ORDER = bpa_pkg::MAX_ORDER_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // operation, request_bytes, free_address
  input  wire logic [bpa_pkg::IN_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // status, block_address, block_order
  output logic [bpa_pkg::OUT_W-1:0]      m_tdata,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [bpa_pkg::CFG_W-1:0] cfg_data
);

  bpa_pkg::cmd_t  cmd;
  bpa_pkg::stat_t st;

  bpa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .st(st), .cmd(cmd)
  );

  bpa_dpath #(.MAX_PAGES(MAX_PAGES), .MAX_ORDER(MAX_ORDER)) u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st), .in_data(s_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
  );

  assign s_tready = cmd.take;

endmodule

`default_nettype wire
